// ===== rtl/sha256_pkg.sv =====
package sha256_pkg;

    typedef logic [7:0][31:0] word8_t;
    typedef logic [15:0][31:0] window_t;

    localparam int unsigned ROUNDS = 64;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ===== rtl/sha256_round.sv =====
module sha256_round
(
    input  sha256_pkg::word8_t  work,
    input  logic [31:0]         w0,
    input  logic [31:0]         w1,
    input  logic [31:0]         w9,
    input  logic [31:0]         w14,
    input  logic [5:0]          rnd,
    output sha256_pkg::word8_t  work_out,
    output logic [31:0]         w_new
);

    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] f;
    logic [31:0] g;
    logic [31:0] h;
    logic [31:0] big_s0;
    logic [31:0] big_s1;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] sm_s0;
    logic [31:0] sm_s1;

    assign a = work[0];
    assign b = work[1];
    assign c = work[2];
    assign d = work[3];
    assign e = work[4];
    assign f = work[5];
    assign g = work[6];
    assign h = work[7];

    assign big_s1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    assign big_s0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    assign ch     = (e & f) ^ (~e & g);
    assign maj    = (a & b) ^ (a & c) ^ (b & c);
    assign t1     = h + big_s1 + ch + sha256_pkg::ROUND_K[rnd] + w0;
    assign t2     = big_s0 + maj;

    always_comb
    begin
        work_out[7] = g;
        work_out[6] = f;
        work_out[5] = e;
        work_out[4] = d + t1;
        work_out[3] = c;
        work_out[2] = b;
        work_out[1] = a;
        work_out[0] = t1 + t2;
    end

    // schedule word sixteen rounds ahead
    assign sm_s0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b000, w1[31:3]};
    assign sm_s1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ {10'd0, w14[31:10]};
    assign w_new = sm_s1 + w9 + sm_s0 + w0;

endmodule

// ===== rtl/sha256_hash_engine.sv =====
// flow: accepted bytes are absorbed one per cycle while s_tready is high; every full 64-byte
// block then runs its 64 rounds on the shared round unit in ST_ROUND, then one chain add in ST_ADDC
// a final request feeds padding and length bytes at one per cycle, pausing while a padded block
// compresses; the eight digest words follow, one per cycle while m_tready is high
// input is accepted only in ST_IDLE, so no bytes are taken while the single round unit compresses a block
// reset: asynchronous active low; chain returns to the initial hash words, no clearing pass
module sha256_hash_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // byte_present
    input  logic        s_tlast,   // final_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word
    output logic [2:0]  m_tuser,   // word_index
    output logic        m_tlast    // last_word
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADDC,
        ST_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [5:0]             rnd_reg, rnd_next;
    logic [5:0]             bib_reg, bib_next;
    logic [63:0]            len_reg, len_next;
    logic [23:0]            acc_reg, acc_next;
    sha256_pkg::window_t    win_reg, win_next;
    sha256_pkg::word8_t     chain_reg, chain_next;
    sha256_pkg::word8_t     work_reg, work_next;
    logic                   pad_reg, pad_next;
    logic                   mark_reg, mark_next;
    logic                   lenph_reg, lenph_next;
    logic [2:0]             oidx_reg, oidx_next;

    logic                   put_en;
    logic [7:0]             put_b;
    sha256_pkg::word8_t     round_work;
    logic [31:0]            round_w;

    sha256_round u_round
    (
        .work     (work_reg),
        .w0       (win_reg[0]),
        .w1       (win_reg[1]),
        .w9       (win_reg[9]),
        .w14      (win_reg[14]),
        .rnd      (rnd_reg),
        .work_out (round_work),
        .w_new    (round_w)
    );

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        bib_next   = bib_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        win_next   = win_reg;
        chain_next = chain_reg;
        work_next  = work_reg;
        pad_next   = pad_reg;
        mark_next  = mark_reg;
        lenph_next = lenph_reg;
        oidx_next  = oidx_reg;
        put_en     = 1'b0;
        put_b      = 8'h00;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        put_en   = 1'b1;
                        put_b    = s_tdata;
                        len_next = len_reg + 64'd8;
                    end
                    if (s_tlast)
                    begin
                        pad_next = 1'b1;
                        if (!(s_tuser && bib_reg == 6'd63))
                        begin
                            state_next = ST_PAD;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                put_en = 1'b1;
                if (!mark_reg)
                begin
                    put_b     = sha256_pkg::PAD_MARK;
                    mark_next = 1'b1;
                end
                else if (lenph_reg || bib_reg == sha256_pkg::LEN_OFFSET)
                begin
                    // length goes out msb first, leaving the register cleared
                    lenph_next = 1'b1;
                    put_b      = len_reg[63:56];
                    len_next   = {len_reg[55:0], 8'h00};
                end
            end
            ST_ROUND:
            begin
                work_next = round_work;
                win_next  = {round_w, win_reg[15:1]};
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'(sha256_pkg::ROUNDS - 1))
                begin
                    state_next = ST_ADDC;
                end
            end
            ST_ADDC:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                if (lenph_reg)
                begin
                    state_next = ST_OUT;
                    oidx_next  = 3'd0;
                    pad_next   = 1'b0;
                    mark_next  = 1'b0;
                    lenph_next = 1'b0;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    // shift the digest out while refilling with the initial words
                    chain_next = {sha256_pkg::INIT_H[oidx_reg], chain_reg[7:1]};
                    oidx_next  = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (put_en)
        begin
            acc_next = {acc_reg[15:0], put_b};
            bib_next = bib_reg + 6'd1;
            if (bib_reg[1:0] == 2'd3)
            begin
                win_next = {{acc_reg, put_b}, win_reg[15:1]};
            end
            if (bib_reg == 6'(sha256_pkg::BLOCK_BYTES - 1))
            begin
                work_next  = chain_reg;
                rnd_next   = 6'd0;
                state_next = ST_ROUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= 6'd0;
            bib_reg   <= 6'd0;
            len_reg   <= 64'd0;
            pad_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            lenph_reg <= 1'b0;
            oidx_reg  <= 3'd0;
            work_reg  <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sha256_pkg::INIT_H[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            bib_reg   <= bib_next;
            len_reg   <= len_next;
            pad_reg   <= pad_next;
            mark_reg  <= mark_next;
            lenph_reg <= lenph_next;
            oidx_reg  <= oidx_next;
            work_reg  <= work_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        win_reg <= win_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = chain_reg[0];
    assign m_tuser  = oidx_reg;
    assign m_tlast  = (oidx_reg == 3'd7);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output sides active together");

    a_block_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser && bib_reg == 6'd63) |=> (state_reg == ST_ROUND))
        else $error("full block did not start compression");

    a_round_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (bib_reg == 6'd0))
        else $error("compression running on a partial block");

    a_idle_counter: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ROUND) |-> (rnd_reg == 6'd0))
        else $error("round counter not cleared between blocks");

    a_digest_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && len_reg == 64'd0))
        else $error("engine not back to a fresh message after digest");

endmodule

// ===== verif/tb_sha256_hash_engine.sv =====
module tb_sha256_hash_engine;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       fin;
    } byte_req_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // data_byte
    logic        s_tuser = 1'b0;    // byte_present
    logic        s_tlast = 1'b0;    // final_item
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // digest_word
    logic [2:0]  m_tuser;           // word_index
    logic        m_tlast;           // last_word

    sha256_hash_engine dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [31:0] hash_chain [8];
    logic [31:0] msg_window [16];
    logic [5:0]  block_pos;
    logic [63:0] msg_bits;

    byte_req_t    pending_q [$];
    digest_word_t expected_digest_q [$];

    int  err_cnt = 0;
    int  queued_items = 0;
    int  req_count = 0;
    int  msg_count = 0;
    int  byte_count = 0;
    int  words_checked = 0;
    int  in_stall_cycles = 0;
    bit  req_taken = 1'b0;
    bit  out_taken = 1'b0;
    bit  hold_off = 1'b0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;
    int  tx_wait = 0;
    int  rx_wait = 0;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2, x15, x2;
        for (int i = 0; i < 8; i++)
            v[i] = hash_chain[i];
        for (int t = 0; t < sha256_pkg::ROUNDS; t++)
        begin
            if (t >= 16)
            begin
                x15 = msg_window[(t - 15) & 15];
                x2 = msg_window[(t - 2) & 15];
                s0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
                s1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
                msg_window[t & 15] = s1 + msg_window[(t - 7) & 15] + s0 + msg_window[t & 15];
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[t]
                 + msg_window[t & 15];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_chain[i] = hash_chain[i] + v[i];
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        logic [3:0] w;
        int         shift;
        w = block_pos[5:2];
        shift = 24 - 8 * block_pos[1:0];
        if (block_pos[1:0] == 2'd0)
            msg_window[w] = {24'd0, b} << shift;
        else
            msg_window[w] = msg_window[w] | ({24'd0, b} << shift);
        block_pos = block_pos + 6'd1;
        if (block_pos == 6'd0)
            compress_block();
    endtask

    task automatic hash_request(input byte_req_t r);
        digest_word_t d;
        if (r.present)
        begin
            absorb_byte(r.data);
            msg_bits = msg_bits + 64'd8;
        end
        if (r.fin)
        begin
            absorb_byte(sha256_pkg::PAD_MARK);
            while (block_pos != sha256_pkg::LEN_OFFSET)
                absorb_byte(8'h00);
            msg_window[14] = msg_bits[63:32];
            msg_window[15] = msg_bits[31:0];
            compress_block();
            block_pos = 6'd0;
            for (int k = 0; k < 8; k++)
            begin
                d.word = hash_chain[k];
                d.idx = 3'(k);
                d.last = (k == 7);
                expected_digest_q.push_back(d);
            end
            hash_chain = sha256_pkg::INIT_H;
            msg_bits = 64'd0;
        end
    endtask

    task automatic report_mismatch(input string what);
        if (err_cnt < 50)
            $display("mismatch at %0t ns: %s", $time, what);
        err_cnt++;
    endtask

    task automatic push_req(input logic [7:0] data, input bit present, input bit fin);
        byte_req_t r;
        r.data = data;
        r.present = present;
        r.fin = fin;
        pending_q.push_back(r);
        queued_items++;
    endtask

    // one message of len bytes with occasional idle items between; the end mark rides on the last byte or stands alone
    task automatic add_message(input int len, input bit tail_on_byte);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                push_req(8'($urandom), 1'b0, 1'b0);
            push_req(8'($urandom), 1'b1, tail_on_byte && (i == len - 1));
        end
        if (len == 0 || !tail_on_byte)
            push_req(8'($urandom), 1'b0, 1'b1);
    endtask

    // input side: predict on every accepted request
    always @(posedge clk)
    begin
        byte_req_t r;
        if (rst_n && s_tvalid && !s_tready)
            in_stall_cycles++;
        if (rst_n && s_tvalid && s_tready)
        begin
            r.data = s_tdata;
            r.present = s_tuser;
            r.fin = s_tlast;
            hash_request(r);
            req_taken = 1'b1;
            req_count++;
            if (r.present)
                byte_count++;
            if (r.fin)
                msg_count++;
        end
    end

    always @(negedge clk)
    begin
        byte_req_t nxt;
        logic      v;
        if (rst_n)
        begin
            v = s_tvalid;
            if (req_taken)
            begin
                v = 1'b0;
                req_taken = 1'b0;
            end
            if (!v)
            begin
                if (tx_wait > 0)
                    tx_wait--;
                else if (pending_q.size() != 0)
                begin
                    nxt = pending_q.pop_front();
                    s_tdata <= nxt.data;
                    s_tuser <= nxt.present;
                    s_tlast <= nxt.fin;
                    v = 1'b1;
                    if ($urandom_range(0, 31) == 0)
                        tx_burst = !tx_burst;
                    tx_wait = tx_burst ? 0 : $urandom_range(0, 12);
                end
            end
            s_tvalid <= v;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                out_taken = 1'b0;
                if ($urandom_range(0, 31) == 0)
                    rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 12);
            end
            if (hold_off)
                m_tready <= 1'b0;
            else if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        digest_word_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            out_taken = 1'b1;
            words_checked++;
            if (expected_digest_q.size() == 0)
                report_mismatch($sformatf("digest word %h with nothing expected", m_tdata));
            else
            begin
                e = expected_digest_q.pop_front();
                if (m_tdata !== e.word)
                    report_mismatch($sformatf("word %0d: got %h, want %h",
                                              e.idx, m_tdata, e.word));
                if (m_tuser !== e.idx)
                    report_mismatch($sformatf("word index: got %0d, want %0d", m_tuser, e.idx));
                if (m_tlast !== e.last)
                    report_mismatch($sformatf("last flag on word %0d: got %b, want %b",
                                              e.idx, m_tlast, e.last));
            end
        end
    end

    // long receiver hold-off so the engine backs up into its input
    initial
    begin
        while (req_count < 100)
            @(posedge clk);
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #10ms;
        $display("timeout: engine stopped making progress");
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int len;
        int sel;
        hash_chain = sha256_pkg::INIT_H;
        for (int i = 0; i < 16; i++)
            msg_window[i] = 32'd0;
        block_pos = 6'd0;
        msg_bits = 64'd0;

        // directed: empty message, single extreme bytes, idle items, short strings
        push_req(8'h5a, 1'b0, 1'b1);
        push_req(8'h00, 1'b1, 1'b1);
        push_req(8'hff, 1'b1, 1'b1);
        push_req(8'hc3, 1'b0, 1'b0);
        push_req(8'ha5, 1'b1, 1'b0);
        push_req(8'h3c, 1'b0, 1'b0);
        push_req(8'h00, 1'b0, 1'b1);
        push_req(8'h61, 1'b1, 1'b0);
        push_req(8'h62, 1'b1, 1'b0);
        push_req(8'h63, 1'b1, 1'b1);
        push_req(8'h80, 1'b1, 1'b0);
        push_req(8'h7f, 1'b1, 1'b0);
        push_req(8'hff, 1'b0, 1'b1);

        // random messages, a share of them sized around the padding boundaries
        while (queued_items < 410)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
                len = $urandom_range(0, 12);
            else if (sel < 80)
            begin
                case ($urandom_range(0, 5))
                    0: len = 55;
                    1: len = 56;
                    2: len = 57;
                    3: len = 63;
                    4: len = 64;
                    default: len = 119;
                endcase
            end
            else
                len = $urandom_range(13, 80);
            if (len > 410 - queued_items)
                len = 410 - queued_items;
            add_message(len, $urandom_range(0, 1));
        end

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_digest_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("hashed %0d messages, %0d bytes over %0d requests; %0d digest words checked",
                 msg_count, byte_count, req_count, words_checked);
        $display("input held back for %0d cycles by a full engine; %0d mismatches",
                 in_stall_cycles, err_cnt);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
